>>> rtl/core/led_env_pkg.sv
// Package for the LED envelope generator: widths, register indexes, mode codes.
// Depends on nothing.
package led_env_pkg;

  localparam int TimeWidthDef  = 32;
  localparam int LevelWidthDef = 16;
  localparam int CfgIdxWidth   = 3;
  localparam int CfgDataWidth  = 16;

  localparam logic [2:0] CFG_LEVEL_A = 3'd0;
  localparam logic [2:0] CFG_LEVEL_B = 3'd1;
  localparam logic [2:0] CFG_FADE_A  = 3'd2;
  localparam logic [2:0] CFG_FADE_B  = 3'd3;
  localparam logic [2:0] CFG_HOLD_A  = 3'd4;
  localparam logic [2:0] CFG_HOLD_B  = 3'd5;
  localparam logic [2:0] CFG_REPEAT  = 3'd6;
  localparam logic [2:0] CFG_STOP    = 3'd7;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;
  localparam logic [1:0] MODE_TERM  = 2'd3;

endpackage

>>> rtl/core/led_env_if.sv
// Valid/ready channel interfaces for the envelope generator.
// Depends on nothing.
interface led_env_in_if #(parameter int LW = 16);
  logic          valid;
  logic          ready;
  logic [1:0]    mode;
  logic [LW-1:0] start_level;
  logic          stop_at_start;
  modport source (output valid, mode, start_level, stop_at_start, input ready);
  modport sink   (input valid, mode, start_level, stop_at_start, output ready);
endinterface

interface led_env_out_if #(parameter int LW = 16);
  logic          valid;
  logic          ready;
  logic [LW-1:0] level;
  logic          running;
  modport source (output valid, level, running, input ready);
  modport sink   (input valid, level, running, output ready);
endinterface

>>> rtl/core/led_envelope_generator.sv
// Top level of the LED envelope generator: registers, phase sequencer, output.
// Depends on led_env_pkg, led_env_if and led_env_div.
//
//  channel | dir | payload                           | handshake
//  in_     | in  | mode, start_level, stop_at_start  | valid/ready
//  out_    | out | level, running                    | valid/ready
//  cfg_    | in  | index, data                       | write enable only
//
// One item at a time. Non-tick items and idle ticks go from acceptance to
// S_OUT, which presents their result. A tick walks the phases in S_PH; a fade
// sample that needs the quotient waits in S_FWAIT, almost all of its time in
// the serial multiply/divide unit (16 multiply and 33 divide steps), and a
// tick can hold two such samples. Reset is synchronous, active low.
// The input waits while a result is held on out_ and not yet taken.
module led_envelope_generator #(
  parameter int TIME_WIDTH  = led_env_pkg::TimeWidthDef,
  parameter int LEVEL_WIDTH = led_env_pkg::LevelWidthDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  led_env_in_if.sink                     in_ch,
  led_env_out_if.source                  out_ch,
  input  logic                           cfg_we,
  input  logic [led_env_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [led_env_pkg::CfgDataWidth-1:0] cfg_data
);
  import led_env_pkg::*;

  localparam int LW = LEVEL_WIDTH;
  localparam int TW = TIME_WIDTH;
  localparam int SW = LW + 1;
  localparam int DW = 16;
  localparam int QW = SW + DW;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PH      = 4'd1;  // evaluate current phase
  localparam logic [3:0] S_FWAIT   = 4'd2;  // wait for divider
  localparam logic [3:0] S_FPOST   = 4'd3;  // finish fade update
  localparam logic [3:0] S_CROSS   = 4'd4;
  localparam logic [3:0] S_OUT     = 4'd5;
  localparam logic [3:0] S_FLAUNCH = 4'd6;  // pick direct endpoint or start divider

  // configuration
  logic signed [LW-1:0] lvl_a_r, lvl_b_r, stop_tgt_r;
  logic [DW-1:0] fade_a_r, fade_b_r, hold_a_r, hold_b_r;
  logic [7:0]    rep_r;

  // state
  logic [3:0]           st_r;
  logic [TW-1:0]        tick_r, pts_r, fst_r;
  logic signed [LW-1:0] from_r, now_r, prev_r, olvl_r, slvl_r;
  logic signed [SW-1:0] span_r;
  logic [DW-1:0]        flen_r;
  logic                 fact_r, stopq_r, act_r, redir_r;
  logic [2:0]           ph_r;
  logic [7:0]           cyc_r;
  logic [TW-1:0]        elapsed;
  logic                 need_div;
  logic                 div_start, div_done;
  logic signed [QW-1:0] div_q;
  logic signed [LW-1:0] fade_val;
  logic signed [LW-1:0] out_lvl_r;
  logic                 out_run_r, out_v_r;

  assign in_ch.ready   = (st_r == S_IDLE) && !out_v_r;
  assign out_ch.valid  = out_v_r;
  assign out_ch.level  = out_lvl_r;
  assign out_ch.running = out_run_r;

  function automatic logic signed [LW-1:0] ext16(input logic [CfgDataWidth-1:0] v);
    return LW'($signed(v));
  endfunction

  assign elapsed = tick_r - fst_r;

  // The quotient is only needed inside the fade; past its end the target is taken.
  assign need_div = (flen_r != '0) && (elapsed <= TW'(flen_r));

  // serial product/quotient of span*elapsed/length; elapsed <= length < 2^16
  assign div_start = (st_r == S_FLAUNCH) && need_div;
  led_env_div #(.AW(SW), .BW(DW)) u_div (
    .clk, .rst_n, .start(div_start),
    .a(span_r), .b(elapsed[DW-1:0]), .d(flen_r),
    .done(div_done), .q(div_q)
  );

  always_ff @(posedge clk) begin
    logic signed [LW-1:0] a, b, s, tgt;
    logic                 rd;
    if (!rst_n) begin
      lvl_a_r <= LW'(16384); lvl_b_r <= '0; stop_tgt_r <= '0;
      fade_a_r <= '0; fade_b_r <= '0; hold_a_r <= '0; hold_b_r <= '0;
      rep_r <= 8'd1;
      st_r <= S_IDLE; tick_r <= '0; pts_r <= '0; fst_r <= '0;
      from_r <= '0; now_r <= '0; prev_r <= '0; olvl_r <= '0; slvl_r <= '0;
      span_r <= '0; flen_r <= '0; fact_r <= 1'b0; stopq_r <= 1'b0;
      act_r <= 1'b0; ph_r <= '0; cyc_r <= '0; redir_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LEVEL_A: lvl_a_r    <= ext16(cfg_data);
          CFG_LEVEL_B: lvl_b_r    <= ext16(cfg_data);
          CFG_FADE_A:  fade_a_r   <= cfg_data;
          CFG_FADE_B:  fade_b_r   <= cfg_data;
          CFG_HOLD_A:  hold_a_r   <= cfg_data;
          CFG_HOLD_B:  hold_b_r   <= cfg_data;
          CFG_REPEAT:  rep_r      <= cfg_data[7:0];
          CFG_STOP:    stop_tgt_r <= ext16(cfg_data);
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) out_v_r <= 1'b0;
      a = lvl_a_r; b = lvl_b_r; s = slvl_r; rd = 1'b0; tgt = '0;
      unique case (st_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            unique case (in_ch.mode)
              MODE_TICK: begin
                tick_r  <= tick_r + 1'b1;
                redir_r <= 1'b0;
                st_r    <= act_r ? S_PH : S_OUT;
              end
              MODE_START: begin
                slvl_r  <= in_ch.stop_at_start ? in_ch.start_level : stop_tgt_r;
                olvl_r  <= in_ch.start_level;
                cyc_r   <= '0; ph_r <= '0; stopq_r <= 1'b0; act_r <= 1'b1;
                st_r    <= S_OUT;
              end
              MODE_STOP: begin stopq_r <= 1'b1; st_r <= S_OUT; end
              default:   begin act_r <= 1'b0; st_r <= S_OUT; end
            endcase
          end
        end
        S_PH: begin
          unique case (ph_r)
            3'd0, 3'd3: begin
              if (ph_r == 3'd0) begin
                if (cyc_r == '0) pts_r <= tick_r;
                if (stopq_r && ((s > a && a > b) || (s < a && a < b))) rd = 1'b1;
                tgt = rd ? s : a;
                flen_r <= fade_a_r;
                ph_r <= 3'd1;
              end else begin
                // redir_r carries an A redirect made earlier in this tick
                rd = redir_r;
                if ((rep_r != '0) && (rep_r == cyc_r + 8'd1)) begin
                  stopq_r <= 1'b1;
                  if ((s < b && b < a) || (s > b && b > a)) rd = 1'b1;
                end else if (stopq_r && ((s < b && b < a) || (s > b && b > a))) begin
                  rd = 1'b1;
                end
                tgt = rd ? s : b;
                flen_r <= fade_b_r;
                ph_r <= 3'd4;
              end
              redir_r <= rd;
              now_r  <= olvl_r;
              from_r <= olvl_r;
              span_r <= SW'(tgt) - SW'(olvl_r);
              fst_r  <= tick_r;
              fact_r <= 1'b1;
            end
            3'd1, 3'd4: begin
              if (fact_r) begin
                st_r <= S_FLAUNCH;
              end else begin
                pts_r <= pts_r + TW'(ph_r == 3'd1 ? fade_a_r : fade_b_r);
                ph_r  <= ph_r + 3'd1;
              end
            end
            3'd2: begin
              if ((tick_r - pts_r) < TW'(hold_a_r)) st_r <= S_CROSS;
              else begin ph_r <= 3'd3; pts_r <= pts_r + TW'(hold_a_r); end
            end
            3'd5: begin
              if ((tick_r - pts_r) >= TW'(hold_b_r)) begin
                ph_r <= 3'd0; cyc_r <= cyc_r + 8'd1;
                pts_r <= pts_r + TW'(hold_b_r);
              end
              st_r <= S_CROSS;
            end
            default: st_r <= S_CROSS;
          endcase
        end
        S_FLAUNCH: begin
          if (need_div) begin
            st_r <= S_FWAIT;
          end else begin
            st_r <= S_FPOST; now_r <= from_r + LW'(span_r); prev_r <= now_r;
          end
        end
        S_FWAIT: begin
          if (div_done) begin
            st_r <= S_FPOST; now_r <= fade_val; prev_r <= now_r;
          end
        end
        S_FPOST: begin
          olvl_r <= now_r;
          if (elapsed >= TW'(flen_r)) begin
            fact_r <= 1'b0;
            st_r   <= S_PH;
          end else begin
            st_r <= S_CROSS;
          end
        end
        S_CROSS: begin
          if (stopq_r && fact_r &&
              ((now_r >= s && prev_r <= s) || (now_r <= s && prev_r >= s))) begin
            fact_r <= 1'b0; now_r <= s; act_r <= 1'b0;
          end
          st_r <= S_OUT;
        end
        S_OUT: begin
          out_v_r <= 1'b1;
          st_r    <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign fade_val = from_r + LW'(div_q);

  always_ff @(posedge clk) begin
    if (st_r == S_OUT) begin
      out_lvl_r <= olvl_r;
      out_run_r <= act_r;
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (st_r == S_IDLE && !out_v_r))
    else $error("input accepted while busy");
  a_out_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT) |=> out_v_r)
    else $error("result not presented");
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r != 3'd6 && ph_r != 3'd7)
    else $error("unused phase code reached");
`endif
endmodule

>>> rtl/core/led_env_div.sv
// Bit-serial signed multiply and restoring divide: q = (a * b) / d, truncated.
// Depends on led_env_pkg (only for style); fully parameterized.
module led_env_div #(
  parameter int AW = 17,
  parameter int BW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [AW-1:0] a,
  input  logic        [BW-1:0] b,
  input  logic        [BW-1:0] d,
  output logic                 done,
  output logic signed [AW+BW-1:0] q
);
  import led_env_pkg::*;

  localparam int PW = AW + BW;
  localparam int CW = $clog2(PW + 1);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] acc_r, acc_nxt;    // product, then quotient bits shift in
  logic [PW-1:0] mcand_r, mcand_nxt;
  logic [BW-1:0] mplier_r, mplier_nxt;
  logic [BW:0]   rem_r, rem_nxt;
  logic [BW-1:0] d_r, d_nxt;
  logic          neg_r, neg_nxt;
  logic [BW:0]   trial;

  assign trial = {rem_r[BW-1:0], acc_r[PW-1]} - {1'b0, d_r};

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    rem_nxt    = rem_r;
    d_nxt      = d_r;
    neg_nxt    = neg_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          neg_nxt    = a[AW-1];
          mcand_nxt  = PW'(a[AW-1] ? -a : a);
          mplier_nxt = b;
          d_nxt      = d;
          acc_nxt    = '0;
          cnt_nxt    = CW'(BW);
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          rem_nxt   = '0;
          cnt_nxt   = CW'(PW);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // One quotient bit per cycle from the top of the product.
        if (!trial[BW]) begin
          rem_nxt = trial;
          acc_nxt = {acc_r[PW-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[BW-1:0], acc_r[PW-1]};
          acc_nxt = {acc_r[PW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) state_nxt = S_FIN;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    rem_r    <= rem_nxt;
    d_r      <= d_nxt;
    neg_r    <= neg_nxt;
  end

  assign done = (state_r == S_FIN);
  assign q    = neg_r ? -$signed(acc_r) : $signed(acc_r);

`ifndef ASSERT_OFF
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_DIV) |-> cnt_r != '0)
    else $error("serial counter reached zero inside a pass");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done)
    else $error("divider done held for more than one cycle");
  a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == CW'(1)) |=> done)
    else $error("divider did not finish after its last bit");
`endif
endmodule

>>> verif/tb_led_envelope_generator.sv
// Self-checking testbench for the LED envelope generator: directed and random transactions.
// Depends on led_env_pkg, led_env_if and the led_envelope_generator RTL.
`timescale 1ns / 1ps
module tb_led_envelope_generator;
  import led_env_pkg::*;

  localparam int LW = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  led_env_in_if #(.LW(LW)) in_ch ();
  led_env_out_if #(.LW(LW)) out_ch ();

  led_envelope_generator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  typedef struct packed {
    logic [LW-1:0] level;
    logic running;
  } env_result_t;

  // Predictor registers and state.
  logic signed [15:0] lvl_a, lvl_b, stop_tgt;
  logic [15:0] fade_a, fade_b, hold_a, hold_b;
  logic [7:0] repeats;
  logic [31:0] now_t, phase_ts, fstart;
  longint f_from, f_span, f_now, f_prev, out_lvl, latched_stop;
  logic [15:0] f_len;
  logic [7:0] cyc;
  int unsigned ph;
  bit f_act, stop_req, env_on;

  env_result_t expected_q[$];
  int mismatches = 0;
  int stall_hold = 0;
  int idle_pct = 23;
  int quiet = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_TICK;
    in_ch.start_level = '0;
    in_ch.stop_at_start = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic void model_reset();
    lvl_a = 16384; lvl_b = 0; stop_tgt = 0;
    fade_a = 0; fade_b = 0; hold_a = 0; hold_b = 0; repeats = 1;
    now_t = 0; phase_ts = 0; fstart = 0;
    f_from = 0; f_span = 0; f_now = 0; f_prev = 0; out_lvl = 0; latched_stop = 0;
    f_len = 0; cyc = 0; ph = 0; f_act = 0; stop_req = 0; env_on = 0;
  endfunction

  function automatic void fade_start(longint from, longint to, logic [15:0] len);
    f_now = from; f_from = from; f_span = to - from; f_len = len;
    fstart = now_t; f_act = 1;
  endfunction

  function automatic bit fade_sample();
    logic [31:0] el;
    longint v;
    if (!f_act) return 0;
    el = now_t - fstart;
    v = f_from + f_span;
    if (f_len > 0 && el <= f_len) v = f_from + (f_span * longint'(el)) / longint'(f_len);
    if (el >= f_len) f_act = 0;
    f_prev = f_now; f_now = v;
    return 1;
  endfunction

  function automatic void advance_envelope();
    bit redir = 0;
    longint a = lvl_a, b = lvl_b, s = latched_stop;
    bit go = 1;
    if (ph > 5) go = 0;
    if (go && ph == 0) begin
      if (cyc == 0) phase_ts = now_t;
      if (stop_req && ((s > a && a > b) || (s < a && a < b))) redir = 1;
      fade_start(out_lvl, redir ? s : a, fade_a);
      ph = 1;
    end
    if (go && ph == 1) begin
      if (fade_sample()) out_lvl = f_now;
      if (f_act) go = 0;
      else begin phase_ts = phase_ts + fade_a; ph = 2; end
    end
    if (go && ph == 2) begin
      if (32'(now_t - phase_ts) < hold_a) go = 0;
      else begin ph = 3; phase_ts = phase_ts + hold_a; end
    end
    if (go && ph == 3) begin
      if (repeats != 0 && repeats == 8'(cyc + 8'd1)) stop_req = 1;
      if (stop_req && ((s < b && b < a) || (s > b && b > a))) redir = 1;
      fade_start(out_lvl, redir ? s : b, fade_b);
      ph = 4;
    end
    if (go && ph == 4) begin
      if (fade_sample()) out_lvl = f_now;
      if (f_act) go = 0;
      else begin phase_ts = phase_ts + fade_b; ph = 5; end
    end
    if (go && ph == 5) begin
      if (32'(now_t - phase_ts) >= hold_b) begin
        ph = 0; cyc = cyc + 8'd1; phase_ts = phase_ts + hold_b;
      end
    end
    if (stop_req && f_act) begin
      if ((f_now >= s && f_prev <= s) || (f_now <= s && f_prev >= s)) begin
        f_act = 0; f_now = s; env_on = 0;
      end
    end
  endfunction

  function automatic env_result_t predict_envelope(logic [1:0] mode,
                                                   logic [15:0] init, bit sas);
    env_result_t r;
    case (mode)
      MODE_TICK: begin
        now_t = now_t + 1;
        if (env_on) advance_envelope();
      end
      MODE_START: begin
        latched_stop = sas ? longint'($signed(init)) : longint'(stop_tgt);
        out_lvl = $signed(init); cyc = 0; ph = 0; stop_req = 0; env_on = 1;
      end
      MODE_STOP: stop_req = 1;
      default: env_on = 0;
    endcase
    r.level = out_lvl[15:0];
    r.running = env_on;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LEVEL_A: lvl_a = val;
      CFG_LEVEL_B: lvl_b = val;
      CFG_FADE_A: fade_a = val;
      CFG_FADE_B: fade_b = val;
      CFG_HOLD_A: hold_a = val;
      CFG_HOLD_B: hold_b = val;
      CFG_REPEAT: repeats = val[7:0];
      default: stop_tgt = val;
    endcase
  endtask

  task automatic set_profile(logic [15:0] a, logic [15:0] b, logic [15:0] fa,
                             logic [15:0] fb, logic [15:0] ha, logic [15:0] hb,
                             logic [7:0] rep, logic [15:0] st);
    wait (expected_q.size() == 0);
    repeat (10) @(negedge clk);
    write_reg(CFG_LEVEL_A, a); write_reg(CFG_LEVEL_B, b);
    write_reg(CFG_FADE_A, fa); write_reg(CFG_FADE_B, fb);
    write_reg(CFG_HOLD_A, ha); write_reg(CFG_HOLD_B, hb);
    write_reg(CFG_REPEAT, {8'd0, rep}); write_reg(CFG_STOP, st);
  endtask

  // Drives one transaction, with an optional idle gap before it.
  task automatic send_item(logic [1:0] mode, logic [15:0] init, bit sas);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_ch.valid <= 1'b1; in_ch.mode <= mode;
    in_ch.start_level <= init; in_ch.stop_at_start <= sas;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(predict_envelope(mode, init, sas));
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Receiver readiness, including the long hold-off when requested.
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    env_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result level=%h", out_ch.level);
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.level !== out_ch.level || exp_r.running !== out_ch.running) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected level=%h running=%b, got level=%h running=%b",
                     exp_r.level, exp_r.running, out_ch.level, out_ch.running);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb_led_envelope_generator: FAIL");
      $finish;
    end
  end

  task automatic run_ticks(int n);
    repeat (n) send_item(MODE_TICK, 16'($urandom), 1'($urandom));
  endtask

  task automatic test_directed();
    set_profile(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd1, 16'd0);
    send_item(MODE_TICK, 16'hFFFF, 1'b1);
    send_item(MODE_STOP, 16'h0000, 1'b0);
    send_item(MODE_TERM, 16'h8000, 1'b1);
    send_item(MODE_START, 16'h8000, 1'b0);
    run_ticks(2);
    set_profile(16'h7FFF, 16'h8000, 16'd3, 16'd2, 16'd1, 16'd1, 8'd2, 16'h0000);
    send_item(MODE_START, 16'h0000, 1'b0);
    run_ticks(8);
    send_item(MODE_STOP, 16'h0000, 1'b0);
    run_ticks(6);
    send_item(MODE_START, 16'h7FFF, 1'b1);
    send_item(MODE_TERM, 16'h0000, 1'b0);
    run_ticks(1);
  endtask

  task automatic test_backpressure();
    set_profile(16'd8000, 16'hE000, 16'd4, 16'd4, 16'd2, 16'd2, 8'd0, 16'd0);
    send_item(MODE_START, 16'd0, 1'b0);
    stall_hold = 300;
    run_ticks(20);
  endtask

  task automatic test_random();
    int k;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_profile(16'hFFFF, 16'h0001, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 8'd255, 16'h8000);
        1: set_profile(16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 8'd3, 16'h7FFF);
        default: set_profile(16'($urandom), 16'($urandom), 16'($urandom_range(12)),
                             16'($urandom_range(12)), 16'($urandom_range(5)),
                             16'($urandom_range(5)), 8'($urandom_range(4)),
                             16'($urandom));
      endcase
      idle_pct = (p == 3) ? 0 : 23;
      k = 0;
      while (k < 105) begin
        if ($urandom_range(99) < 8) begin
          send_item(MODE_START, 16'($urandom), 1'($urandom));
        end else if ($urandom_range(99) < 5) begin
          send_item(MODE_STOP, 16'($urandom), 1'($urandom));
        end else if ($urandom_range(99) < 3) begin
          send_item(MODE_TERM, 16'($urandom), 1'($urandom));
        end else begin
          send_item(MODE_TICK, 16'($urandom), 1'($urandom));
        end
        k++;
      end
    end
    idle_pct = 23;
  endtask

  initial begin
    model_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    wait (expected_q.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_led_envelope_generator: PASS");
    end else begin
      $display("tb_led_envelope_generator: FAIL");
    end
    $finish;
  end

endmodule
